// ===== design/triple_box_blur_row_defines.svh =====
// Assertion macros shared by the blur row design.
`ifndef TRIPLE_BOX_BLUR_ROW_DEFINES_SVH
`define TRIPLE_BOX_BLUR_ROW_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define TBBR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define TBBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tbbr_pkg.sv =====
// Types, constants and lookup functions for the triple box blur row.
`timescale 1ns / 1ps

package tbbr_pkg;

  // Geometry of the filter and of the pixel format.
  localparam int MAX_BOX_WIDTH = 16;
  localparam int MAX_ROW_WIDTH = 1024;
  localparam int CHANNEL_BITS  = 5;
  localparam int NUM_CH        = 3;
  localparam int PIXEL_BITS    = NUM_CH * CHANNEL_BITS;
  localparam int SCALE_SHIFT   = 14;

  // Register and internal widths.
  localparam int BOX_BITS     = 5;
  localparam int ROW_BITS     = 11;
  localparam int IDX_BITS     = 4;
  localparam int POS_BITS     = 12;
  localparam int S1_BITS      = 9;
  localparam int S2_BITS      = 13;
  localparam int S3_BITS      = 17;
  localparam int SCALE_BITS   = 15;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_BITS     = 15;
  localparam int PROD_BITS    = SCALE_BITS + S3_BITS;

  localparam logic [CHANNEL_BITS-1:0] CH_MAX = 5'h1F;

  // Values after reset.
  localparam int RESET_BOX_INT = 3;
  localparam int RESET_HALF    = 3 * RESET_BOX_INT / 2 - 1;
  localparam int RESET_CUBE    = RESET_BOX_INT * RESET_BOX_INT * RESET_BOX_INT;
  localparam logic [BOX_BITS-1:0]   RESET_BOX_WIDTH = BOX_BITS'(RESET_BOX_INT);
  localparam logic [ROW_BITS-1:0]   RESET_ROW_WIDTH = 11'd640;
  localparam logic [PIXEL_BITS-1:0] RESET_BACK      = '0;
  localparam logic signed [POS_BITS-1:0] RESET_POS  = POS_BITS'(-(RESET_HALF + 5));
  localparam logic [S3_BITS-1:0]    RESET_HALF_CUBE = S3_BITS'(RESET_CUBE / 2);
  localparam logic [SCALE_BITS-1:0] RESET_SCALE     = SCALE_BITS'(16384 / RESET_CUBE);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_BOX_WIDTH  = 2'd0,
    CFG_ROW_WIDTH  = 2'd1,
    CFG_BACK_COLOR = 2'd2
  } cfg_idx_e;

  // Channel payloads.
  typedef struct packed {
    logic [PIXEL_BITS-1:0] src_pixel;
    logic                  frame_start;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] out_pixel;
    logic                  row_end;
  } out_item_t;

  // One step as decided at acceptance.
  typedef struct packed {
    logic [PIXEL_BITS-1:0] pix;
    logic [IDX_BITS-1:0]   idx;
    logic                  frame_start;
    logic                  emit;
    logic                  last;
    logic [S3_BITS-1:0]    half_cube;
    logic [SCALE_BITS-1:0] scale;
  } step_t;

  // One entry of the delay memory: all three rings of all channels.
  typedef struct packed {
    logic [NUM_CH-1:0][CHANNEL_BITS-1:0] raw;
    logic [NUM_CH-1:0][S1_BITS-1:0]      s1;
    logic [NUM_CH-1:0][S2_BITS-1:0]      s2;
  } delay_word_t;

  // Memory port controls.
  typedef struct packed {
    logic                rd_en;
    logic [IDX_BITS-1:0] rd_addr;
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    logic                clear;
  } mem_req_t;

  // Third sums waiting for the scale multiply.
  typedef struct packed {
    logic [NUM_CH-1:0][S3_BITS-1:0] third;
    logic [SCALE_BITS-1:0]          scale;
    logic                           row_end;
  } prod_t;

  // Pipeline status seen by the top level.
  typedef struct packed {
    logic                a_valid;
    logic                a_adv;
    logic                a_emit;
    logic                a_frame_start;
    logic [IDX_BITS-1:0] a_idx;
    logic                p_valid;
  } stage_stat_t;

  // 16384 / w^3, indexed by w - 1.
  function automatic logic [SCALE_BITS-1:0] scale_lut(input logic [IDX_BITS-1:0] wm1);
    logic [SCALE_BITS-1:0] r;
    case (wm1)
      4'd0:    r = 15'd16384;
      4'd1:    r = 15'd2048;
      4'd2:    r = 15'd606;
      4'd3:    r = 15'd256;
      4'd4:    r = 15'd131;
      4'd5:    r = 15'd75;
      4'd6:    r = 15'd47;
      4'd7:    r = 15'd32;
      4'd8:    r = 15'd22;
      4'd9:    r = 15'd16;
      4'd10:   r = 15'd12;
      4'd11:   r = 15'd9;
      4'd12:   r = 15'd7;
      4'd13:   r = 15'd5;
      4'd14:   r = 15'd4;
      default: r = 15'd4;
    endcase
    return r;
  endfunction

  // w^3 / 2 rounded down, indexed by w - 1.
  function automatic logic [S3_BITS-1:0] half_cube_lut(input logic [IDX_BITS-1:0] wm1);
    logic [S3_BITS-1:0] r;
    case (wm1)
      4'd0:    r = 17'd0;
      4'd1:    r = 17'd4;
      4'd2:    r = 17'd13;
      4'd3:    r = 17'd32;
      4'd4:    r = 17'd62;
      4'd5:    r = 17'd108;
      4'd6:    r = 17'd171;
      4'd7:    r = 17'd256;
      4'd8:    r = 17'd364;
      4'd9:    r = 17'd500;
      4'd10:   r = 17'd665;
      4'd11:   r = 17'd864;
      4'd12:   r = 17'd1098;
      4'd13:   r = 17'd1372;
      4'd14:   r = 17'd1687;
      default: r = 17'd2048;
    endcase
    return r;
  endfunction

endpackage

// ===== design/tbbr_delay_store.sv =====
// Delay line memory with per-entry valid bits and write-to-read forwarding.
`timescale 1ns / 1ps

module tbbr_delay_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tbbr_pkg::mem_req_t    req_i,
  input  tbbr_pkg::delay_word_t wr_data_i,
  output tbbr_pkg::delay_word_t rd_data_o
);
  import tbbr_pkg::*;

  delay_word_t                mem_q [MAX_BOX_WIDTH];
  delay_word_t                rd_data_q;
  delay_word_t                fwd_data_q;
  logic                       fwd_q;
  logic [IDX_BITS-1:0]        rd_addr_q;
  logic [MAX_BOX_WIDTH-1:0]   vld_q, vld_d;

  // Memory array: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_data_q  <= mem_q[req_i.rd_addr];
      rd_addr_q  <= req_i.rd_addr;
      fwd_data_q <= wr_data_i;
    end
  end

  // Valid bits: a frame start clears them all, a write marks its entry.
  always_comb begin
    vld_d = vld_q;
    if (req_i.clear) begin
      vld_d = '0;
    end else if (req_i.wr_en) begin
      vld_d[req_i.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      fwd_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (req_i.rd_en) begin
        fwd_q <= req_i.wr_en && !req_i.clear && (req_i.wr_addr == req_i.rd_addr);
      end
    end
  end

  // A read that met a write to the same entry takes the written word.
  always_comb begin
    if (fwd_q) begin
      rd_data_o = fwd_data_q;
    end else if (vld_q[rd_addr_q]) begin
      rd_data_o = rd_data_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

// ===== design/tbbr_step_ctrl.sv =====
// Configuration registers, row position, ring index and scale latch.
`timescale 1ns / 1ps

module tbbr_step_ctrl (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tbbr_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [tbbr_pkg::CFG_BITS-1:0]         cfg_data_i,
  input  logic                                  accept_i,
  input  tbbr_pkg::in_item_t                    in_data_i,
  output tbbr_pkg::step_t                       step_o
);
  import tbbr_pkg::*;

  logic [BOX_BITS-1:0]          box_width_q;
  logic [ROW_BITS-1:0]          row_width_q;
  logic [PIXEL_BITS-1:0]        back_color_q;
  logic [IDX_BITS-1:0]          ring_q, ring_d;
  logic signed [POS_BITS-1:0]   pos_q, pos_d;
  logic [SCALE_BITS-1:0]        scale_q;

  logic [BOX_BITS-1:0]          w;
  logic [IDX_BITS-1:0]          wm1;
  logic [BOX_BITS+1:0]          three_w;
  logic [BOX_BITS:0]            half;
  logic [ROW_BITS-1:0]          rw;
  logic signed [POS_BITS-1:0]   rw_s, use_w, p_init, p;
  logic [IDX_BITS-1:0]          idx;
  logic [BOX_BITS-1:0]          idx_inc;
  logic                         in_use, last;

  assign cfg_ready_o = 1'b1;

  // Effective widths, clamped into range.
  always_comb begin
    if (box_width_q == '0) begin
      w = BOX_BITS'(1);
    end else if (box_width_q > BOX_BITS'(MAX_BOX_WIDTH)) begin
      w = BOX_BITS'(MAX_BOX_WIDTH);
    end else begin
      w = box_width_q;
    end
    if (row_width_q == '0) begin
      rw = ROW_BITS'(1);
    end else if (row_width_q > ROW_BITS'(MAX_ROW_WIDTH)) begin
      rw = ROW_BITS'(MAX_ROW_WIDTH);
    end else begin
      rw = row_width_q;
    end
  end

  // Row geometry derived from the widths.
  assign wm1     = IDX_BITS'(w - BOX_BITS'(1));
  assign three_w = {2'b00, w} + {1'b0, w, 1'b0};
  assign half    = three_w[BOX_BITS+1:1] - (BOX_BITS+1)'(1);
  assign rw_s    = {1'b0, rw};
  assign use_w   = rw_s - POS_BITS'(half) - POS_BITS'(w[0]);
  assign p_init  = POS_BITS'(0) - POS_BITS'(half) - POS_BITS'(5);

  // A frame start makes this step the first of a fresh row.
  assign p       = in_data_i.frame_start ? p_init : pos_q;
  assign idx     = in_data_i.frame_start ? '0 : ring_q;
  assign in_use  = !p[POS_BITS-1] && (p < use_w);
  assign last    = p >= (rw_s - POS_BITS'(1));
  assign idx_inc = {1'b0, idx} + BOX_BITS'(1);
  assign ring_d  = (idx_inc >= w) ? '0 : idx_inc[IDX_BITS-1:0];
  assign pos_d   = last ? p_init : p + POS_BITS'(1);

  // Step descriptor handed to the update stage.
  always_comb begin
    step_o.pix         = in_use ? in_data_i.src_pixel : back_color_q;
    step_o.idx         = idx;
    step_o.frame_start = in_data_i.frame_start;
    step_o.emit        = !p[POS_BITS-1];
    step_o.last        = last;
    step_o.half_cube   = half_cube_lut(wm1);
    step_o.scale       = in_data_i.frame_start ? scale_lut(wm1) : scale_q;
  end

  // Registers: configuration writes and per-step control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_width_q  <= RESET_BOX_WIDTH;
      row_width_q  <= RESET_ROW_WIDTH;
      back_color_q <= RESET_BACK;
      ring_q       <= '0;
      pos_q        <= RESET_POS;
      scale_q      <= RESET_SCALE;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_BOX_WIDTH:  box_width_q  <= cfg_data_i[BOX_BITS-1:0];
          CFG_ROW_WIDTH:  row_width_q  <= cfg_data_i[ROW_BITS-1:0];
          CFG_BACK_COLOR: back_color_q <= cfg_data_i[PIXEL_BITS-1:0];
          default: ;
        endcase
      end
      if (accept_i) begin
        ring_q <= ring_d;
        pos_q  <= pos_d;
        if (in_data_i.frame_start) begin
          scale_q <= step_o.scale;
        end
      end
    end
  end

endmodule

// ===== design/tbbr_sum_update.sv =====
// Read-modify-write stage: running sums, delay memory update, sum hand-off.
`timescale 1ns / 1ps

module tbbr_sum_update (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  tbbr_pkg::step_t        step_i,
  output logic                   ready_o,
  output tbbr_pkg::mem_req_t     mem_req_o,
  output tbbr_pkg::delay_word_t  wr_data_o,
  input  tbbr_pkg::delay_word_t  rd_data_i,
  input  logic                   out_free_i,
  output logic                   prod_valid_o,
  output tbbr_pkg::prod_t        prod_o,
  output tbbr_pkg::stage_stat_t  stat_o
);
  import tbbr_pkg::*;

  step_t                          a_q;
  logic                           a_valid_q;
  logic                           a_adv;
  logic                           p_valid_q;
  logic                           p_free;
  prod_t                          p_q;
  logic [NUM_CH-1:0][S1_BITS-1:0] s1_q, n1;
  logic [NUM_CH-1:0][S2_BITS-1:0] s2_q, n2;
  logic [NUM_CH-1:0][S3_BITS-1:0] s3_q, n3;

  // Stage flow: the step in flight retires when its sums have a place to go.
  assign p_free  = !p_valid_q || out_free_i;
  assign a_adv   = a_valid_q && (!a_q.emit || p_free);
  assign ready_o = !a_valid_q || a_adv;

  // Memory port: read for a new step, re-read while a step waits.
  always_comb begin
    mem_req_o.rd_en   = accept_i || (a_valid_q && !a_adv);
    mem_req_o.rd_addr = accept_i ? step_i.idx : a_q.idx;
    mem_req_o.wr_en   = a_adv;
    mem_req_o.wr_addr = a_q.idx;
    mem_req_o.clear   = accept_i && step_i.frame_start;
  end

  // Three cascaded running sums per channel.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      logic [CHANNEL_BITS-1:0] v;
      logic [S1_BITS-1:0]      b1;
      logic [S2_BITS-1:0]      b2;
      logic [S3_BITS-1:0]      b3;
      v  = a_q.pix[(NUM_CH-1-c)*CHANNEL_BITS +: CHANNEL_BITS];
      b1 = a_q.frame_start ? '0 : s1_q[c];
      b2 = a_q.frame_start ? '0 : s2_q[c];
      b3 = a_q.frame_start ? a_q.half_cube : s3_q[c];
      n1[c] = b1 + S1_BITS'(v) - S1_BITS'(rd_data_i.raw[c]);
      n2[c] = b2 + S2_BITS'(n1[c]) - S2_BITS'(rd_data_i.s1[c]);
      n3[c] = b3 + S3_BITS'(n2[c]) - S3_BITS'(rd_data_i.s2[c]);
      wr_data_o.raw[c] = v;
      wr_data_o.s1[c]  = n1[c];
      wr_data_o.s2[c]  = n2[c];
    end
  end

  // Control state and sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      s1_q      <= '0;
      s2_q      <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        s3_q[c] <= RESET_HALF_CUBE;
      end
    end else begin
      if (accept_i) begin
        a_valid_q <= 1'b1;
      end else if (a_adv) begin
        a_valid_q <= 1'b0;
      end
      if (a_adv && a_q.emit) begin
        p_valid_q <= 1'b1;
      end else if (out_free_i) begin
        p_valid_q <= 1'b0;
      end
      if (a_adv) begin
        s1_q <= n1;
        s2_q <= n2;
        s3_q <= n3;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      a_q <= step_i;
    end
    if (a_adv && a_q.emit) begin
      p_q.third   <= n3;
      p_q.scale   <= a_q.scale;
      p_q.row_end <= a_q.last;
    end
  end

  assign prod_valid_o = p_valid_q;
  assign prod_o       = p_q;

  always_comb begin
    stat_o.a_valid       = a_valid_q;
    stat_o.a_adv         = a_adv;
    stat_o.a_emit        = a_q.emit;
    stat_o.a_frame_start = a_q.frame_start;
    stat_o.a_idx         = a_q.idx;
    stat_o.p_valid       = p_valid_q;
  end

endmodule

// ===== design/tbbr_scale_out.sv =====
// Scale multiply, saturation and the output register.
`timescale 1ns / 1ps

module tbbr_scale_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                prod_valid_i,
  input  tbbr_pkg::prod_t     prod_i,
  output logic                out_free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tbbr_pkg::out_item_t out_data_o
);
  import tbbr_pkg::*;

  logic                  out_valid_q;
  out_item_t             out_q;
  logic [PIXEL_BITS-1:0] pix;
  logic                  load;

  assign out_free_o = !out_valid_q || out_ready_i;
  assign load       = prod_valid_i && out_free_o;

  // Per channel: (scale * sum) >> 14, clipped to the channel maximum.
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      logic [PROD_BITS-1:0]             m;
      logic [PROD_BITS-SCALE_SHIFT-1:0] q;
      m = PROD_BITS'(prod_i.scale) * PROD_BITS'(prod_i.third[c]);
      q = m[PROD_BITS-1:SCALE_SHIFT];
      if (|q[PROD_BITS-SCALE_SHIFT-1:CHANNEL_BITS]) begin
        pix[(NUM_CH-1-c)*CHANNEL_BITS +: CHANNEL_BITS] = CH_MAX;
      end else begin
        pix[(NUM_CH-1-c)*CHANNEL_BITS +: CHANNEL_BITS] = q[CHANNEL_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_pixel <= pix;
      out_q.row_end   <= prod_i.row_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/triple_box_blur_row.sv =====
// Triple box blur row: three cascaded box filters over RGB555 pixels along a row.
//
// Each input transaction is one step of the row; steps at non-negative positions
// produce one output transaction. The block takes one step per clock while input
// ready is high: every step reads and writes a 16-entry delay memory holding all
// three delay rings; the write of one step is forwarded to the read of the next
// when they hit the same entry. A result passes the memory read, registered at the
// edge that accepts its step, then the sum update into the sum stage and the scale
// multiply into the output register. A frame start does not stall the input:
// per-entry valid bits clear the delay memory at once. Input ready drops only when
// a result waits in the sum stage while the output register is not taken.
// Configuration writes are taken on every cycle.
`timescale 1ns / 1ps
`include "triple_box_blur_row_defines.svh"

module triple_box_blur_row (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  tbbr_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output tbbr_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tbbr_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [tbbr_pkg::CFG_BITS-1:0]     cfg_data_i
);
  import tbbr_pkg::*;

  logic        in_accept;
  logic        out_free;
  logic        prod_valid;
  step_t       step;
  mem_req_t    mem_req;
  delay_word_t wr_data;
  delay_word_t rd_data;
  prod_t       prod;
  stage_stat_t stat;
  logic        frame_acc;
  logic        frame_held;
  logic        out_stuck;
  logic        emit_adv;
  logic        a_stalled;
  logic        stall_rd_ok;

  assign in_accept = in_valid_i && in_ready_o;

  // Step decode and configuration.
  tbbr_step_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_accept),
    .in_data_i   (in_data_i),
    .step_o      (step)
  );

  // Delay line memory.
  tbbr_delay_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  // Running sum update.
  tbbr_sum_update u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .step_i       (step),
    .ready_o      (in_ready_o),
    .mem_req_o    (mem_req),
    .wr_data_o    (wr_data),
    .rd_data_i    (rd_data),
    .out_free_i   (out_free),
    .prod_valid_o (prod_valid),
    .prod_o       (prod),
    .stat_o       (stat)
  );

  // Scaling and output register.
  tbbr_scale_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_i       (prod),
    .out_free_o   (out_free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // Conditions watched by the checks below.
  assign frame_acc   = in_accept && in_data_i.frame_start;
  assign frame_held  = stat.a_valid && stat.a_frame_start && (stat.a_idx == '0);
  assign out_stuck   = stat.p_valid && !out_free;
  assign emit_adv    = stat.a_adv && stat.a_emit;
  assign a_stalled   = stat.a_valid && !stat.a_adv;
  assign stall_rd_ok = mem_req.rd_en && (mem_req.rd_addr == stat.a_idx) && !mem_req.wr_en;

  // A frame start step always begins at ring entry zero.
  `TBBR_ASSERT_NEXT(a_frame_idx_chk, frame_acc, frame_held, "frame start not at entry zero")
  // A result must never retire into a sum stage that cannot drain.
  `TBBR_ASSERT_IMPLIES(p_overrun_chk, out_stuck, !emit_adv, "sum stage overwritten on stall")
  // A waiting step keeps reading its own entry so its data stays current.
  `TBBR_ASSERT_IMPLIES(stall_read_chk, a_stalled, stall_rd_ok, "stalled step lost its read")

endmodule

// ===== verif/triple_box_blur_row_test.sv =====
// Self-checking testbench for the triple box blur row block.
`timescale 1ns / 1ps

module triple_box_blur_row_test;
  import tbbr_pkg::*;

  localparam int RANDOM_ITEMS  = 750;
  localparam int SETTLE_CYCLES = 6;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PRESSURE_HOLD = 300;
  localparam int REPORT_LIMIT  = 10;

  // Mirror of the blur state: the three rings, the running sums and the row position.
  // It turns each source transaction into the blurred pixel it should produce.
  class triple_sum_tracker;
    logic [BOX_BITS-1:0]   box_reg;
    logic [ROW_BITS-1:0]   row_reg;
    logic [PIXEL_BITS-1:0] back_reg;
    int unsigned raw_ring [NUM_CH][MAX_BOX_WIDTH];
    int unsigned s1_ring [NUM_CH][MAX_BOX_WIDTH];
    int unsigned s2_ring [NUM_CH][MAX_BOX_WIDTH];
    int unsigned first_sum [NUM_CH];
    int unsigned second_sum [NUM_CH];
    int unsigned third_sum [NUM_CH];
    int unsigned ring_pos;
    int          step_pos;
    int unsigned scale;
    out_item_t   blurred_due [$];
    int          bad_pixels;

    function new();
      box_reg    = RESET_BOX_WIDTH;
      row_reg    = RESET_ROW_WIDTH;
      back_reg   = RESET_BACK;
      bad_pixels = 0;
      start_frame();
    endfunction

    // Box width as used: zero acts as one, anything above the maximum is clipped.
    function int unsigned box_len();
      if (box_reg == 0) return 1;
      if (box_reg > MAX_BOX_WIDTH) return MAX_BOX_WIDTH;
      return box_reg;
    endfunction

    function int row_len();
      if (row_reg == 0) return 1;
      if (row_reg > MAX_ROW_WIDTH) return MAX_ROW_WIDTH;
      return int'(row_reg);
    endfunction

    function int half_len(input int unsigned w);
      return int'(3 * w / 2) - 1;
    endfunction

    // Frame start: clear rings and sums, seed the third sum for rounding, latch the scale.
    function void start_frame();
      int unsigned w;
      int unsigned cube;
      w    = box_len();
      cube = w * w * w;
      foreach (raw_ring[c, i]) begin
        raw_ring[c][i] = 0;
        s1_ring[c][i]  = 0;
        s2_ring[c][i]  = 0;
      end
      foreach (first_sum[c]) begin
        first_sum[c]  = 0;
        second_sum[c] = 0;
        third_sum[c]  = cube >> 1;
      end
      ring_pos = 0;
      step_pos = -half_len(w) - 5;
      scale    = (1 << SCALE_SHIFT) / cube;
    endfunction

    function void write_reg(input cfg_idx_e idx, input logic [CFG_BITS-1:0] data);
      case (idx)
        CFG_BOX_WIDTH:  box_reg  = data[BOX_BITS-1:0];
        CFG_ROW_WIDTH:  row_reg  = data[ROW_BITS-1:0];
        CFG_BACK_COLOR: back_reg = data[PIXEL_BITS-1:0];
        default: ;
      endcase
    endfunction

    // One accepted source transaction is one step of the row loop.
    function void take_source(input in_item_t item);
      int unsigned w;
      int unsigned pix;
      int unsigned idx;
      int unsigned v;
      int half;
      int rw;
      int use_w;
      int p;
      int c;
      longint unsigned level;
      logic [PIXEL_BITS-1:0] blurred;
      out_item_t res;
      if (item.frame_start) start_frame();
      w     = box_len();
      half  = half_len(w);
      rw    = row_len();
      use_w = rw - half - int'(w & 1);
      p     = step_pos;
      // Source pixels only inside the used span, padding color everywhere else.
      if (p >= 0 && p < use_w) pix = item.src_pixel;
      else pix = back_reg;
      idx = (ring_pos >= MAX_BOX_WIDTH) ? 0 : ring_pos;
      for (c = 0; c < NUM_CH; c++) begin
        v = (pix >> (CHANNEL_BITS * (2 - c))) & CH_MAX;
        first_sum[c]  += v - raw_ring[c][idx];
        raw_ring[c][idx] = v;
        second_sum[c] += first_sum[c] - s1_ring[c][idx];
        s1_ring[c][idx] = first_sum[c];
        third_sum[c]  += second_sum[c] - s2_ring[c][idx];
        s2_ring[c][idx] = second_sum[c];
        level = scale;
        level = (level * third_sum[c]) >> SCALE_SHIFT;
        if (level > CH_MAX) level = CH_MAX;
        blurred[CHANNEL_BITS * (2 - c) +: CHANNEL_BITS] = level[CHANNEL_BITS-1:0];
      end
      ring_pos = (idx + 1 >= w) ? 0 : idx + 1;
      if (p >= 0) begin
        res.out_pixel = blurred;
        res.row_end   = (p >= rw - 1);
        blurred_due.push_back(res);
      end
      step_pos = (p >= rw - 1) ? -half - 5 : p + 1;
    endfunction

    function void check_blurred(input out_item_t got);
      out_item_t want;
      if (blurred_due.size() == 0) begin
        bad_pixels++;
        if (bad_pixels <= REPORT_LIMIT)
          $display("Unexpected output transaction: pixel %h row_end %b",
                   got.out_pixel, got.row_end);
        return;
      end
      want = blurred_due.pop_front();
      if (got.out_pixel !== want.out_pixel || got.row_end !== want.row_end) begin
        bad_pixels++;
        if (bad_pixels <= REPORT_LIMIT)
          $display("Mismatch: expected pixel %h row_end %b, got pixel %h row_end %b",
                   want.out_pixel, want.row_end, got.out_pixel, got.row_end);
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  in_item_t                in_data_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  out_item_t               out_data_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [CFG_BITS-1:0]     cfg_data_i;

  triple_sum_tracker tracker;
  int send_gap_pct;
  int recv_gap_pct;
  int recv_hold_left = 0;
  int quiet_cycles = 0;

  triple_box_blur_row dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (recv_hold_left > 0) begin
        out_ready_i <= 1'b0;
        recv_hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  // Observe every transaction on the three channels.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) tracker.take_source(in_data_i);
      if (cfg_valid_i && cfg_ready_o) tracker.write_reg(cfg_idx_e'(cfg_index_i), cfg_data_i);
      if (out_valid_o && out_ready_i) tracker.check_blurred(out_data_o);
    end
  end

  // Watchdog: end the run when no channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // A run of steps; patterned runs cycle through the pixel extremes.
  task automatic send_run(input int count, input bit fresh, input bit patterned);
    in_item_t item;
    int k;
    for (k = 0; k < count; k++) begin
      if (patterned) begin
        case (k % 4)
          0:       item.src_pixel = 15'h7FFF;
          1:       item.src_pixel = 15'h0000;
          2:       item.src_pixel = 15'h5555;
          default: item.src_pixel = 15'h2AAA;
        endcase
        item.frame_start = fresh && k == 0;
      end else begin
        item.src_pixel   = PIXEL_BITS'($urandom_range(0, 32767));
        item.frame_start = (fresh && k == 0) || ($urandom_range(99) < 3);
      end
      send_item(item);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic configure(input logic [CFG_BITS-1:0] box, input logic [CFG_BITS-1:0] row,
                           input logic [CFG_BITS-1:0] back);
    write_reg(CFG_BOX_WIDTH, box);
    write_reg(CFG_ROW_WIDTH, row);
    write_reg(CFG_BACK_COLOR, back);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop offering, wait for every expected pixel, then let the pipeline go quiet.
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.blurred_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int phase;
    int sent;
    int count;
    bit fresh;
    logic [CFG_BITS-1:0] box_val;
    logic [CFG_BITS-1:0] row_val;
    tracker = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_BOX_WIDTH;
    cfg_data_i  <= '0;
    send_gap_pct = 22;
    recv_gap_pct = 85;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Width two, short row, magenta padding: a row up to but not including its last step.
    configure(15'd2, 15'd4, 15'h7C1F);
    send_run(10, 1'b1, 1'b1);
    wait_results_done();
    // Width and row both out of range, no frame start: the position is past the row end.
    configure(15'd31, 15'd0, 15'h7FFF);
    send_run(1, 1'b0, 1'b1);
    wait_results_done();
    // Zero width acts as one; the widest row.
    configure(15'd0, 15'h07FF, 15'h03E0);
    send_run(6, 1'b1, 1'b1);
    wait_results_done();
    // Width grows mid-frame while the scale stays latched, so channels saturate.
    configure(15'd5, 15'h07FF, 15'h03E0);
    send_run(4, 1'b0, 1'b1);
    wait_results_done();
    // Row shrinks mid-row.
    configure(15'd5, 15'd3, 15'h03E0);
    send_run(1, 1'b0, 1'b1);

    // Random runs in three idling phases.
    for (phase = 0; phase < 3; phase++) begin
      send_gap_pct = (phase == 0) ? 22 : (phase == 1) ? 85 : 0;
      recv_gap_pct = (phase == 0) ? 85 : (phase == 1) ? 22 : 0;
      sent = 0;
      if (phase == 2) begin
        // Long receiver hold-off while the sender keeps offering.
        wait_results_done();
        configure(15'd3, 15'd8, PIXEL_BITS'($urandom_range(0, 32767)));
        recv_hold_left = PRESSURE_HOLD;
        send_run(40, 1'b1, 1'b0);
        sent += 40;
      end
      while (sent < RANDOM_ITEMS / 3) begin
        wait_results_done();
        if ($urandom_range(3) != 0) begin
          case ($urandom_range(9))
            0:       box_val = '0;
            1:       box_val = 15'd31;
            2:       box_val = 15'd16;
            3:       box_val = CFG_BITS'($urandom_range(0, 32767));
            default: box_val = CFG_BITS'($urandom_range(1, 16));
          endcase
          case ($urandom_range(9))
            0:       row_val = '0;
            1:       row_val = 15'd1;
            2:       row_val = 15'd1024;
            3:       row_val = 15'd2047;
            4:       row_val = CFG_BITS'($urandom_range(0, 32767));
            default: row_val = CFG_BITS'($urandom_range(1, 48));
          endcase
          configure(box_val, row_val, CFG_BITS'($urandom_range(0, 32767)));
        end
        // Mostly a fresh frame; sometimes the settings change in the middle of one.
        fresh = ($urandom_range(3) != 0);
        count = $urandom_range(8, 60);
        send_run(count, fresh, 1'b0);
        sent += count;
      end
    end

    wait_results_done();
    if (tracker.bad_pixels == 0 && tracker.blurred_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
